// File: hdl/lru_recency_tracker_core_macros.svh
// assertion macros used by lru_recency_tracker_core
`ifndef LRU_RECENCY_TRACKER_CORE_MACROS_SVH
`define LRU_RECENCY_TRACKER_CORE_MACROS_SVH

// same-cycle implication, checked on clk, muted in reset
`define LRT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on clk, muted in reset
`define LRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/lrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lrt_pkg;

    localparam int ENTRIES      = 8;
    localparam int KEY_BITS     = 32;
    localparam int SLOT_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W       = SLOT_W;
    localparam int COUNT_W      = $clog2(ENTRIES + 1);
    localparam int CAP_W        = 4;
    localparam int CAP_RESET    = 8;
    localparam int LIM_W        = (COUNT_W > CAP_W) ? COUNT_W : CAP_W;
    localparam int FIELD_SLOT_W = 3;
    localparam int KIND_W       = 2;
    localparam int STATUS_W     = 2;
    localparam int TDATA_W      = ((FIELD_SLOT_W + KEY_BITS + 7) / 8) * 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_TOUCH  = 2'd1,
        KIND_EVICT  = 2'd2,
        KIND_BAD    = 2'd3
    } lrt_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_INVALID = 2'd3
    } lrt_status_t;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_INSERT = 2'd1,
        OP_TOUCH  = 2'd2,
        OP_EVICT  = 2'd3
    } lrt_op_t;

    // broadcast to every cell, independent of the chain results
    typedef struct packed {
        logic [SLOT_W-1:0] touch_slot;
        logic [RANK_W-1:0] victim_rank;
    } lrt_lookup_t;

    // broadcast update, decided from the chain results
    typedef struct packed {
        lrt_op_t             op;
        logic [RANK_W-1:0]   touch_rank;
        logic [KEY_BITS-1:0] key;
    } lrt_update_t;

    // handed from one cell to the next
    typedef struct packed {
        logic                free_seen;
        logic [SLOT_W-1:0]   free_slot;
        logic                sel_valid;
        logic [RANK_W-1:0]   sel_rank;
        logic                vic_found;
        logic [SLOT_W-1:0]   vic_slot;
        logic [KEY_BITS-1:0] vic_key;
    } lrt_link_t;

endpackage

`default_nettype wire

// File: hdl/lrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module lrt_cell
    import lrt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [SLOT_W-1:0] idx,
    input  wire lrt_lookup_t       lookup,
    input  wire lrt_update_t       upd,
    input  wire lrt_link_t         link_in,
    output lrt_link_t              link_out
);

    logic                valid_reg, valid_next;
    logic [RANK_W-1:0]   rank_reg, rank_next;
    logic [KEY_BITS-1:0] key_reg, key_next;

    logic claim;
    logic is_sel;
    logic is_vic;

    assign claim  = !valid_reg && !link_in.free_seen;
    assign is_sel = valid_reg && (idx == lookup.touch_slot);
    assign is_vic = valid_reg && (rank_reg == lookup.victim_rank);

    // chain: first free slot, touched slot rank, least recent entry
    always_comb
    begin
        link_out           = link_in;
        link_out.free_seen = link_in.free_seen || !valid_reg;
        if (claim)
        begin
            link_out.free_slot = idx;
        end
        if (is_sel)
        begin
            link_out.sel_valid = 1'b1;
            link_out.sel_rank  = rank_reg;
        end
        if (is_vic)
        begin
            link_out.vic_found = 1'b1;
            link_out.vic_slot  = idx;
            link_out.vic_key   = key_reg;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        key_next   = key_reg;
        case (upd.op)
            OP_INSERT:
            begin
                if (valid_reg)
                begin
                    rank_next = rank_reg + 1'b1;
                end
                else if (claim)
                begin
                    valid_next = 1'b1;
                    rank_next  = '0;
                    key_next   = upd.key;
                end
            end
            OP_TOUCH:
            begin
                if (is_sel)
                begin
                    rank_next = '0;
                end
                else if (valid_reg && (rank_reg < upd.touch_rank))
                begin
                    rank_next = rank_reg + 1'b1;
                end
            end
            OP_EVICT:
            begin
                if (is_vic)
                begin
                    valid_next = 1'b0;
                    rank_next  = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

`default_nettype wire

// File: hdl/lru_recency_tracker_core.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  handshake            payload
// s_*       in         s_tvalid / s_tready  tuser: kind; tdata: slot, key
// m_*       out        m_tvalid / m_tready  tuser: status; tdata: slot_out, evicted_key
// cfg_*     in         cfg_valid/cfg_ready  cfg_data: capacity
//
// one item a cycle unless the output stalls: the request is resolved in the cycle it is
// accepted and its result lands in the output register on the same edge
// the cell chain settles free slot, touched rank and victim in that one cycle
// s_tready is low only while a result waits and m_tready is low
// cfg_ready is always high; capacity resets to 8
// reset clears valid bits, ranks, count and the output valid flag; keys and the
// output data are not cleared

`include "lru_recency_tracker_core_macros.svh"

module lru_recency_tracker_core
    import lrt_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,   // slot [2:0], key, zero pad
    input  wire logic [KIND_W-1:0]  s_tuser,   // kind
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,   // slot_out [2:0], evicted_key, zero pad
    output logic [STATUS_W-1:0]     m_tuser,   // status
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [CAP_W-1:0]   cfg_data   // capacity
);

    // input fields
    lrt_kind_t               in_kind;
    logic [FIELD_SLOT_W-1:0] in_slot;
    logic [KEY_BITS-1:0]     in_key;

    assign in_kind = lrt_kind_t'(s_tuser);
    assign in_slot = s_tdata[FIELD_SLOT_W-1:0];
    assign in_key  = s_tdata[FIELD_SLOT_W +: KEY_BITS];

    // control state
    logic [CAP_W-1:0]   cap_reg;
    logic [COUNT_W-1:0] count_reg, count_next;

    // output register
    logic                    out_valid_reg, out_valid_next;
    lrt_status_t             status_reg, status_next;
    logic [FIELD_SLOT_W-1:0] slot_reg, slot_next;
    logic [KEY_BITS-1:0]     key_reg, key_next;

    logic accept;

    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // cell chain
    lrt_link_t   links [0:ENTRIES];
    lrt_lookup_t lookup;
    lrt_update_t upd;

    assign links[0]           = '0;
    assign lookup.touch_slot  = SLOT_W'(in_slot);
    assign lookup.victim_rank = RANK_W'(count_reg - 1'b1);

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        lrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .idx      (SLOT_W'(i)),
            .lookup   (lookup),
            .upd      (upd),
            .link_in  (links[i]),
            .link_out (links[i+1])
        );
    end

    // capacity above the number of slots behaves as the number of slots
    logic [LIM_W-1:0] cap_limit;
    logic             slot_in_range;
    logic             ins_ok;
    logic             touch_ok;
    logic             evict_ok;

    assign cap_limit     = (LIM_W'(cap_reg) > LIM_W'(ENTRIES)) ? LIM_W'(ENTRIES)
                                                               : LIM_W'(cap_reg);
    assign slot_in_range = (int'(in_slot) < ENTRIES);
    assign ins_ok        = (LIM_W'(count_reg) < cap_limit) && links[ENTRIES].free_seen;
    assign touch_ok      = slot_in_range && links[ENTRIES].sel_valid;
    assign evict_ok      = (count_reg != '0) && links[ENTRIES].vic_found;

    // request decode
    always_comb
    begin
        upd.op         = OP_NONE;
        upd.touch_rank = links[ENTRIES].sel_rank;
        upd.key        = in_key;
        count_next     = count_reg;
        status_next    = ST_OK;
        slot_next      = '0;
        key_next       = '0;
        unique case (in_kind)
            KIND_INSERT:
            begin
                if (ins_ok)
                begin
                    upd.op     = OP_INSERT;
                    count_next = count_reg + 1'b1;
                    slot_next  = FIELD_SLOT_W'(links[ENTRIES].free_slot);
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            KIND_TOUCH:
            begin
                if (touch_ok)
                begin
                    upd.op = OP_TOUCH;
                end
                else
                begin
                    status_next = ST_INVALID;
                end
            end
            KIND_EVICT:
            begin
                if (evict_ok)
                begin
                    upd.op     = OP_EVICT;
                    count_next = count_reg - 1'b1;
                    slot_next  = FIELD_SLOT_W'(links[ENTRIES].vic_slot);
                    key_next   = links[ENTRIES].vic_key;
                end
                else
                begin
                    status_next = ST_EMPTY;
                end
            end
            default:
            begin
                status_next = ST_INVALID;
            end
        endcase
        // nothing moves unless an item is taken this cycle
        if (!accept)
        begin
            upd.op     = OP_NONE;
            count_next = count_reg;
        end
    end

    // output register: loads on accept, empties when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_W'(CAP_RESET);
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            slot_reg   <= slot_next;
            key_reg    <= key_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = TDATA_W'({key_reg, slot_reg});

    // checks
    `LRT_ASSERT_NOW(a_count_bound, 1'b1, int'(count_reg) <= ENTRIES,
        "entry count above slot count")
    `LRT_ASSERT_NOW(a_full_matches_count, !links[ENTRIES].free_seen,
        int'(count_reg) == ENTRIES, "no free slot while count below slot count")
    `LRT_ASSERT_NEXT(a_insert_counts, accept && (in_kind == KIND_INSERT) && ins_ok,
        count_reg == COUNT_W'($past(count_reg) + 1'b1), "insert did not raise count")
    `LRT_ASSERT_NEXT(a_evict_counts, accept && (in_kind == KIND_EVICT) && evict_ok,
        count_reg == COUNT_W'($past(count_reg) - 1'b1), "evict did not lower count")

endmodule

`default_nettype wire

// File: tb/tb_lru_recency_tracker_core.sv
`timescale 1ns / 1ps

module tb_lru_recency_tracker_core;

    import lrt_pkg::*;

    localparam int PAD_W = TDATA_W - FIELD_SLOT_W - KEY_BITS;

    // one expected reply item as the block should present it
    typedef struct {
        lrt_status_t         status;
        logic [SLOT_W-1:0]   slot_out;
        logic [KEY_BITS-1:0] evicted_key;
    } lru_reply_t;

    // mirror of the recency list plus the queue of replies still owed
    class lru_order_board;
        logic [KEY_BITS-1:0] key_mem [ENTRIES];
        logic [RANK_W-1:0]   rank    [ENTRIES];
        bit                  occupied[ENTRIES];
        int                  fill;
        int                  cap;
        int                  errors;
        int                  requests;
        int                  tally[4];
        lru_reply_t          awaited_replies[$];

        function new();
            for (int i = 0; i < ENTRIES; i++)
            begin
                key_mem[i]  = '0;
                rank[i]     = '0;
                occupied[i] = 1'b0;
            end
            fill     = 0;
            cap      = CAP_RESET;
            errors   = 0;
            requests = 0;
            foreach (tally[i]) tally[i] = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] value);
            cap = value;
        endfunction

        function int outstanding();
            return awaited_replies.size();
        endfunction

        // work out the reply for one accepted request and advance the mirror
        function void note_request(lrt_kind_t kind, logic [SLOT_W-1:0] slot,
                                   logic [KEY_BITS-1:0] key);
            lru_reply_t        r;
            int                free_slot;
            int                lim;
            int                victim;
            logic [RANK_W-1:0] old_rank;
            r.status      = ST_OK;
            r.slot_out    = '0;
            r.evicted_key = '0;
            requests++;
            case (kind)
                KIND_INSERT:
                begin
                    free_slot = -1;
                    for (int i = ENTRIES - 1; i >= 0; i--)
                        if (!occupied[i]) free_slot = i;
                    lim = (cap > ENTRIES) ? ENTRIES : cap;
                    if (fill >= lim || free_slot < 0)
                        r.status = ST_FULL;
                    else
                    begin
                        for (int i = 0; i < ENTRIES; i++)
                            if (occupied[i]) rank[i] = rank[i] + 1'b1;
                        key_mem[free_slot]  = key;
                        rank[free_slot]     = '0;
                        occupied[free_slot] = 1'b1;
                        fill++;
                        r.slot_out = free_slot[SLOT_W-1:0];
                    end
                end
                KIND_TOUCH:
                begin
                    if (!occupied[slot])
                        r.status = ST_INVALID;
                    else
                    begin
                        old_rank = rank[slot];
                        for (int i = 0; i < ENTRIES; i++)
                            if (occupied[i] && rank[i] < old_rank) rank[i] = rank[i] + 1'b1;
                        rank[slot] = '0;
                    end
                end
                KIND_EVICT:
                begin
                    victim = -1;
                    for (int i = 0; i < ENTRIES; i++)
                        if (occupied[i] && (victim < 0 || rank[i] > rank[victim])) victim = i;
                    if (fill == 0 || victim < 0)
                        r.status = ST_EMPTY;
                    else
                    begin
                        r.evicted_key    = key_mem[victim];
                        r.slot_out       = victim[SLOT_W-1:0];
                        occupied[victim] = 1'b0;
                        rank[victim]     = '0;
                        fill--;
                    end
                end
                default: r.status = ST_INVALID;
            endcase
            awaited_replies.push_back(r);
        endfunction

        // compare one accepted reply item with the oldest one owed
        function void check_reply(logic [STATUS_W-1:0] status, logic [TDATA_W-1:0] data);
            lru_reply_t          r;
            logic [SLOT_W-1:0]   got_slot;
            logic [KEY_BITS-1:0] got_key;
            logic [PAD_W-1:0]    got_pad;
            got_slot = data[FIELD_SLOT_W-1:0];
            got_key  = data[FIELD_SLOT_W +: KEY_BITS];
            got_pad  = data[TDATA_W-1 -: PAD_W];
            tally[status]++;
            if (awaited_replies.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected reply, expected none, actual status %0d slot %0d key %h",
                         $time, status, got_slot, got_key);
                return;
            end
            r = awaited_replies.pop_front();
            if (status !== r.status)
            begin
                errors++;
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, r.status, status);
            end
            if (got_slot !== r.slot_out)
            begin
                errors++;
                $display("%0t: slot_out mismatch, expected %0d, actual %0d",
                         $time, r.slot_out, got_slot);
            end
            if (got_key !== r.evicted_key)
            begin
                errors++;
                $display("%0t: evicted_key mismatch, expected %h, actual %h",
                         $time, r.evicted_key, got_key);
            end
            if (got_pad !== '0)
            begin
                errors++;
                $display("%0t: tdata padding mismatch, expected 0, actual %h",
                         $time, got_pad);
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata;   // slot [2:0], key [34:3], zero pad
    logic [KIND_W-1:0]   s_tuser;   // kind
    logic                m_tvalid;
    logic                m_tready;
    logic [TDATA_W-1:0]  m_tdata;   // slot_out [2:0], evicted_key [34:3], zero pad
    logic [STATUS_W-1:0] m_tuser;   // status
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CAP_W-1:0]    cfg_data;  // capacity

    lru_order_board board;
    bit             steady_flow;    // when set neither side idles
    int             cap_writes;

    lru_recency_tracker_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // gap length: mostly none, often short, now and then long
    function automatic int pick_gap();
        int r;
        if (steady_flow) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // observe every handshake on the rising edge; replies are checked before the
    // new request is noted, since a reply always belongs to an earlier item
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                board.check_reply(m_tuser, m_tdata);
            if (s_tvalid && s_tready)
                board.note_request(lrt_kind_t'(s_tuser), s_tdata[FIELD_SLOT_W-1:0],
                                   s_tdata[FIELD_SLOT_W +: KEY_BITS]);
            if (cfg_valid && cfg_ready)
                board.set_capacity(cfg_data);
        end
    end

    // receiver: bursts of ready broken by random stalls
    initial
    begin
        int burst;
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            burst = $urandom_range(1, 20);
            repeat (burst)
            begin
                @(negedge clk);
                m_tready <= 1'b1;
            end
            stall = pick_gap();
            repeat (stall)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
            end
        end
    end

    // offer one request item and hold it until the block takes it
    task automatic send_request(lrt_kind_t kind, logic [SLOT_W-1:0] slot,
                                logic [KEY_BITS-1:0] key);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{PAD_W{1'b0}}, key, slot};
        do @(posedge clk); while (!s_tready);
    endtask

    // stop sending and wait for every owed reply, then a short settle
    task automatic drain_replies();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (board.outstanding() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // capacity is only changed with the block idle
    task automatic write_capacity(logic [CAP_W-1:0] value);
        drain_replies();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cap_writes++;
    endtask

    // pick one occupied slot of the mirror, or a random one if the list is empty
    function automatic logic [SLOT_W-1:0] pick_live_slot();
        int live[$];
        for (int i = 0; i < ENTRIES; i++)
            if (board.occupied[i]) live.push_back(i);
        if (live.size() == 0) return SLOT_W'($urandom_range(0, ENTRIES - 1));
        return SLOT_W'(live[$urandom_range(0, live.size() - 1)]);
    endfunction

    // mostly well-formed traffic on live entries, with some noise mixed in
    task automatic run_traffic(int n_items);
        int                  r;
        lrt_kind_t           kind;
        logic [SLOT_W-1:0]   slot;
        logic [KEY_BITS-1:0] key;
        for (int n = 0; n < n_items; n++)
        begin
            r    = $urandom_range(0, 99);
            slot = SLOT_W'($urandom_range(0, ENTRIES - 1));
            key  = $urandom();
            if (r < 5)
                kind = KIND_BAD;
            else if (r < 11)
                kind = KIND_TOUCH;             // any slot, free ones included
            else if (board.fill == 0 && r < 80)
                kind = KIND_INSERT;
            else if (r < 48)
                kind = KIND_INSERT;
            else if (r < 78)
            begin
                kind = KIND_TOUCH;
                slot = pick_live_slot();
            end
            else
                kind = KIND_EVICT;
            send_request(kind, slot, key);
            // now and then hold off until the block has caught up completely
            if ($urandom_range(0, 199) == 0)
                drain_replies();
        end
    endtask

    initial
    begin
        logic [CAP_W-1:0] cap_plan[5];
        logic [CAP_W-1:0] cap_value;
        board       = new();
        steady_flow = 1'b0;
        cap_writes  = 0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        cap_plan    = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd8};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part, reset capacity of 8
        send_request(KIND_EVICT, 3'd0, 32'h0);              // evict on an empty list
        send_request(KIND_TOUCH, 3'd0, 32'h0);              // touch of a free slot
        send_request(KIND_BAD, 3'd7, 32'hffff_ffff);        // unused kind
        send_request(KIND_INSERT, 3'd7, 32'h0000_0000);     // smallest key
        send_request(KIND_INSERT, 3'd0, 32'hffff_ffff);     // largest key
        send_request(KIND_TOUCH, 3'd1, 32'h0);              // already most recent
        send_request(KIND_TOUCH, 3'd0, 32'h0);              // oldest becomes newest
        send_request(KIND_EVICT, 3'd0, 32'h1234_5678);      // takes slot 1 out
        for (int i = 0; i < 7; i++)
            send_request(KIND_INSERT, 3'(i), 32'ha5a5_0000 + i);
        send_request(KIND_INSERT, 3'd0, 32'hdead_beef);     // list full
        send_request(KIND_TOUCH, 3'd7, 32'h0);
        send_request(KIND_TOUCH, 3'd3, 32'h0);
        send_request(KIND_EVICT, 3'd0, 32'h0);
        send_request(KIND_EVICT, 3'd0, 32'h0);

        // zero capacity refuses every insert
        write_capacity(4'd0);
        send_request(KIND_INSERT, 3'd0, 32'h0bad_f00d);
        send_request(KIND_EVICT, 3'd0, 32'h0);
        // capacity above the slot count behaves like the slot count
        write_capacity(4'd15);
        send_request(KIND_INSERT, 3'd0, 32'h5a5a_5a5a);
        // capacity lowered under the fill: refused until evicts bring it down
        write_capacity(4'd2);
        send_request(KIND_INSERT, 3'd0, 32'h7777_7777);
        while (board.fill >= 2)
        begin
            send_request(KIND_EVICT, 3'd0, 32'h0);
            drain_replies();
        end
        send_request(KIND_INSERT, 3'd0, 32'h3c3c_3c3c);

        // random part over several capacity settings
        for (int phase = 0; phase < 9; phase++)
        begin
            cap_value = (phase < 5) ? cap_plan[phase] : CAP_W'($urandom_range(0, 15));
            write_capacity(cap_value);
            steady_flow = (phase % 4 == 2);
            run_traffic(125);
        end
        steady_flow = 1'b0;

        drain_replies();
        repeat (5) @(posedge clk);
        $display("covered %0d requests across %0d capacity writes", board.requests, cap_writes);
        $display("replies seen: ok %0d, full %0d, empty %0d, invalid %0d",
                 board.tally[ST_OK], board.tally[ST_FULL], board.tally[ST_EMPTY],
                 board.tally[ST_INVALID]);
        if (board.errors == 0 && board.outstanding() == 0)
            $display("lru_recency_tracker_core test passed");
        else
            $display("lru_recency_tracker_core test failed");
        $finish;
    end

    // hard stop well beyond the slowest correct run
    initial
    begin
        #8_000_000;
        $display("lru_recency_tracker_core test failed");
        $finish;
    end

endmodule
